[hdl/shp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_pkg
// Shared widths, register indexes and payload types of the 3x3 sharpen filter.
// ----------------------------------------------------------------------------
package shp_pkg;

   localparam int PIX_W          = 8;
   localparam int OUT_COL_W      = 11;
   localparam int OUT_ROW_W      = 12;
   localparam int WIDTH_REG_W    = 12;
   localparam int HEIGHT_REG_W   = 13;
   localparam int CSR_IDX_W      = 4;
   localparam int CSR_DATA_W     = 16;
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT     = 4096;
   localparam int MIN_DIM        = 3;
   localparam int RESET_WIDTH    = 640;
   localparam int RESET_HEIGHT   = 480;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   typedef struct packed {
      logic [PIX_W-1:0]     red;
      logic [PIX_W-1:0]     green;
      logic [PIX_W-1:0]     blue;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic                 last;
   } result_type;

endpackage

[hdl/shp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_if
// Handshake channels of the sharpen filter: pixel in, result out, register write.
// ----------------------------------------------------------------------------
interface shp_req_if import shp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_in;
   logic [PIX_W-1:0] green_in;
   logic [PIX_W-1:0] blue_in;
   logic             frame_start;

   modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface shp_rsp_if import shp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     red_out;
   logic [PIX_W-1:0]     green_out;
   logic [PIX_W-1:0]     blue_out;
   logic [OUT_COL_W-1:0] out_col;
   logic [OUT_ROW_W-1:0] out_row;
   logic                 frame_last;

   modport source (output valid, red_out, green_out, blue_out, out_col, out_row, frame_last,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, out_col, out_row, frame_last,
                   output ready);
endinterface

interface shp_csr_if import shp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  idx;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, idx, data, input ready);
   modport sink   (input valid, idx, data, output ready);
endinterface

[hdl/shp_line_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_line_store
// Two row memories: row r-1 and row r-2, read by column with registered data.
// ----------------------------------------------------------------------------
module shp_line_store import shp_pkg::*; #(
   parameter int DEPTH = DEF_MAX_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  pixel_type     wr_a_data,
   input  logic          wr_b_en,
   input  logic [AW-1:0] wr_b_addr,
   input  pixel_type     wr_b_data,
   output pixel_type     top,
   output pixel_type     mid
);

   pixel_type mem_a [DEPTH];
   pixel_type mem_b [DEPTH];
   pixel_type a_rd_ff;
   pixel_type b_rd_ff;
   pixel_type byp_data_ff;
   logic      byp_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_rd_ff        <= mem_a[rd_addr];
         mem_a[rd_addr] <= wr_a_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         b_rd_ff     <= mem_b[rd_addr];
         byp_data_ff <= wr_b_data;
      end
      if (wr_b_en) begin
         mem_b[wr_b_addr] <= wr_b_data;
      end
   end

   // same column written and read at one edge after an early frame restart
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_b_en && (wr_b_addr == rd_addr);
      end
   end

   assign mid = a_rd_ff;
   assign top = byp_ff ? byp_data_ff : b_rd_ff;

endmodule

[hdl/shp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_cell
// One window column (top, middle, bottom pixel), passed on to the next column.
// ----------------------------------------------------------------------------
module shp_cell import shp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift,
   input  column_type d,
   output column_type q
);

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift) begin
         col_ff <= d;
      end
   end

   assign q = col_ff;

endmodule

[hdl/shp_kernel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_kernel
// One channel of the cross kernel: five times the center minus four neighbors.
// ----------------------------------------------------------------------------
module shp_kernel import shp_pkg::*; (
   input  logic [PIX_W-1:0] top,
   input  logic [PIX_W-1:0] left,
   input  logic [PIX_W-1:0] centre,
   input  logic [PIX_W-1:0] right,
   input  logic [PIX_W-1:0] bot,
   output logic [PIX_W-1:0] result
);

   localparam int SW = PIX_W + 4;

   logic signed [SW-1:0] acc;

   always_comb begin
      acc = $signed({2'b00, centre, 2'b00}) + $signed({4'b0000, centre})
          - $signed({4'b0000, top}) - $signed({4'b0000, bot})
          - $signed({4'b0000, left}) - $signed({4'b0000, right});
      priority if (acc < 0) begin
         result = '0;
      end else if (acc > $signed(SW'(2**PIX_W - 1))) begin
         result = '1;
      end else begin
         result = acc[PIX_W-1:0];
      end
   end

endmodule

[hdl/sharpen_3x3_rgb_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_rgb_filter
// 3x3 Laplacian sharpen on an RGB raster stream.
//
// Pixels enter on req_ch in raster order, one word per handshake; frame_start
// on a word restarts the row and column count at that pixel. For each interior
// center pixel one word leaves on rsp_ch with the three sharpened channels,
// the center position and frame_last on the last interior pixel of the frame.
// Border pixels give no word.
// Register writes on csr_ch (image_width, image_height) are taken every cycle
// and should be made while the stream is idle.
// Throughput: one pixel per clock while req_ch is ready. The line memories are
// read once per pixel and the two-cell window shifts once per pixel, so a pixel
// can follow in the next cycle. The result word for a pixel passes the compute
// stage registers and then the result queue before it is on rsp_ch.
// When the receiver stalls, results collect in a three-word queue and req_ch
// ready falls only when the queue and the compute stage could overflow.
// Reset sets 640 x 480, clears counters, window and queue; line memories are
// not cleared and need no sweep.
// ----------------------------------------------------------------------------
module sharpen_3x3_rgb_filter import shp_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic   clock,
   input  logic   reset,
   shp_req_if.sink   req_ch,
   shp_rsp_if.source rsp_ch,
   shp_csr_if.sink   csr_ch
);

   localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW     = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
   localparam int HW     = HEIGHT_REG_W;
   localparam int QDEPTH = 3;
   localparam int NCELL  = 2;

   // configuration
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(RESET_WIDTH);
         height_ff <= HEIGHT_REG_W'(RESET_HEIGHT);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.idx)
            REG_IMAGE_WIDTH:  width_ff  <= csr_ch.data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_ch.data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   logic [EW-1:0] eff_w;
   logic [HW-1:0] eff_h;

   always_comb begin
      priority if (EW'(width_ff) < EW'(MIN_DIM)) begin
         eff_w = EW'(MIN_DIM);
      end else if (EW'(width_ff) > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ff);
      end
      priority if (height_ff < HW'(MIN_DIM)) begin
         eff_h = HW'(MIN_DIM);
      end else if (height_ff > HW'(MAX_HEIGHT)) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   // input stage: position counters
   logic                 accept;
   logic [CW-1:0]        col_ff, col_in, cur_col;
   logic [OUT_ROW_W-1:0] row_ff, row_in, cur_row;
   logic [EW-1:0]        col_inc;
   logic [HW-1:0]        row_inc;
   logic                 emit;
   logic                 last;
   pixel_type            px;

   assign accept = req_ch.valid && req_ch.ready;
   assign px     = '{blue: req_ch.blue_in, green: req_ch.green_in, red: req_ch.red_in};

   always_comb begin
      cur_col = (req_ch.frame_start || EW'(col_ff) >= eff_w) ? '0 : col_ff;
      cur_row = (req_ch.frame_start || HW'(row_ff) >= eff_h) ? '0 : row_ff;
      col_inc = EW'(cur_col) + EW'(1);
      row_inc = HW'(cur_row) + HW'(1);
      if (col_inc >= eff_w) begin
         col_in = '0;
         row_in = (row_inc >= eff_h) ? '0 : row_inc[OUT_ROW_W-1:0];
      end else begin
         col_in = col_inc[CW-1:0];
         row_in = cur_row;
      end
      emit = (HW'(cur_row) >= HW'(2)) && (EW'(cur_col) >= EW'(2));
      last = (HW'(cur_row) == eff_h - HW'(1)) && (EW'(cur_col) == eff_w - EW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // compute stage
   logic                 s1_valid_ff;
   logic                 s1_emit_ff;
   pixel_type            s1_px_ff;
   logic [CW-1:0]        s1_col_ff;
   logic [OUT_COL_W-1:0] s1_ocol_ff;
   logic [OUT_ROW_W-1:0] s1_orow_ff;
   logic                 s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_emit_ff  <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= px;
         s1_col_ff  <= cur_col;
         s1_ocol_ff <= OUT_COL_W'(cur_col - CW'(1));
         s1_orow_ff <= cur_row - OUT_ROW_W'(1);
         s1_last_ff <= last;
      end
   end

   pixel_type ls_top, ls_mid;

   shp_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (cur_col),
      .wr_a_data (px),
      .wr_b_en   (s1_valid_ff),
      .wr_b_addr (s1_col_ff),
      .wr_b_data (ls_mid),
      .top       (ls_top),
      .mid       (ls_mid)
   );

   // window: chain of column cells, c-1 then c-2
   column_type cell_d [NCELL];
   column_type cell_q [NCELL];

   assign cell_d[0] = '{top: ls_top, mid: ls_mid, bot: s1_px_ff};

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign cell_d[i] = cell_q[i-1];
      end
      shp_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (s1_valid_ff),
         .d     (cell_d[i]),
         .q     (cell_q[i])
      );
   end

   pixel_type sharp;

   shp_kernel u_kernel_red (
      .top    (cell_q[0].top.red),
      .left   (cell_q[1].mid.red),
      .centre (cell_q[0].mid.red),
      .right  (ls_mid.red),
      .bot    (cell_q[0].bot.red),
      .result (sharp.red)
   );

   shp_kernel u_kernel_green (
      .top    (cell_q[0].top.green),
      .left   (cell_q[1].mid.green),
      .centre (cell_q[0].mid.green),
      .right  (ls_mid.green),
      .bot    (cell_q[0].bot.green),
      .result (sharp.green)
   );

   shp_kernel u_kernel_blue (
      .top    (cell_q[0].top.blue),
      .left   (cell_q[1].mid.blue),
      .centre (cell_q[0].mid.blue),
      .right  (ls_mid.blue),
      .bot    (cell_q[0].bot.blue),
      .result (sharp.blue)
   );

   // result queue
   result_type q_ff [QDEPTH];
   logic [1:0] wr_ptr_ff, rd_ptr_ff, count_ff;
   logic       push, pop;
   result_type q_word;

   assign push   = s1_emit_ff;
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign q_word = '{red: sharp.red, green: sharp.green, blue: sharp.blue,
                     col: s1_ocol_ff, row: s1_orow_ff, last: s1_last_ff};

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == 2'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == 2'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   assign req_ch.ready = ({1'b0, count_ff} + {2'b00, s1_valid_ff}) < 3'(QDEPTH);

   assign rsp_ch.valid      = (count_ff != 2'd0);
   assign rsp_ch.red_out    = q_ff[rd_ptr_ff].red;
   assign rsp_ch.green_out  = q_ff[rd_ptr_ff].green;
   assign rsp_ch.blue_out   = q_ff[rd_ptr_ff].blue;
   assign rsp_ch.out_col    = q_ff[rd_ptr_ff].col;
   assign rsp_ch.out_row    = q_ff[rd_ptr_ff].row;
   assign rsp_ch.frame_last = q_ff[rd_ptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QDEPTH))
      else $error("result queue over its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < 2'(QDEPTH) || pop))
      else $error("result pushed into full queue");

   a_stage_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("taken pixel did not reach compute stage");

   a_restart_col: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.frame_start) |=> (s1_col_ff == '0 && !s1_emit_ff))
      else $error("frame start did not restart the column");

   a_emit_pos: assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |-> (s1_orow_ff != '0 && s1_ocol_ff != '0))
      else $error("result emitted for a border centre");

endmodule
